@@ src/sqvg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sqvg_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 8;
    localparam int ATAN_ENTRIES  = 24;
    localparam int RUN_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int CW            = 34;
    localparam int ZW            = 34;
    localparam int CIDX_W        = (RUN_STAGES > 1) ? $clog2(RUN_STAGES) : 1;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
        logic                 rot;
    } cordic_t;

    typedef struct packed {
        logic signed [24:0] w;
        logic signed [24:0] h;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [24:0] ox;
        logic signed [24:0] oy;
        logic        [15:0] depth;
        logic        [1:0]  flips;
        logic        [31:0] tint;
        logic        [31:0] tmin;
        logic        [31:0] tmax;
    } side_t;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [CIDX_W-1:0] i);
        logic [31:0] v;
        unique case (5'(i))
            5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E; 5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4; 5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55; 5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return ZW'(v);
    endfunction

endpackage
`default_nettype wire

@@ src/sqvg_cordic_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sqvg_cordic_cell
    import sqvg_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire [CIDX_W-1:0]  idx,
    input  wire               en,
    input  wire               vld_in,
    input  cordic_t           cin,
    input  side_t             sin,
    output logic              vld_out,
    output cordic_t           cout,
    output side_t             sout
);
    cordic_t c_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb
    begin
        dx = cin.y >>> idx;
        dy = cin.x >>> idx;
        c_next = cin;
        if (!cin.z[ZW-1])
        begin
            c_next.x = cin.x - dx;
            c_next.y = cin.y + dy;
            c_next.z = cin.z - atan_lut(idx);
        end
        else
        begin
            c_next.x = cin.x + dx;
            c_next.y = cin.y - dy;
            c_next.z = cin.z + atan_lut(idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out <= 1'b0;
        else if (en)
            vld_out <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cout <= c_next;
            sout <= sin;
        end
    end
endmodule
`default_nettype wire

@@ src/sqvg_vertex_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sqvg_vertex_out
    import sqvg_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  cordic_t             cin,
    input  side_t               sin,
    output logic                valid,
    input  wire                 stall,
    output logic [1:0]          corner,
    output logic signed [15:0]  pos_x,
    output logic signed [15:0]  pos_y,
    output logic signed [15:0]  pos_z,
    output logic [15:0]         tex_u,
    output logic [15:0]         tex_v,
    output logic [31:0]         vertex_color,
    output logic                last_vertex
);
    // stage A: hold cos/sin and sprite, step corner; stage B: products; stage C: finish
    logic                 a_vld_reg;
    logic [1:0]           k_reg;
    logic signed [CW-1:0] c_reg, s_reg;
    logic                 rot_reg;
    side_t                sd_reg;

    logic                 b_vld_reg;
    logic signed [67:0]   p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [25:0]   lx_reg, ly_reg;
    logic                 brot_reg;
    logic [1:0]           bk_reg;
    side_t                bsd_reg;

    logic adv_c, adv_b, adv_a;
    assign adv_c = !valid || !stall;
    assign adv_b = !b_vld_reg || adv_c;
    assign adv_a = !a_vld_reg || (adv_b && k_reg == 2'd3);
    assign in_stall = !adv_a;

    logic right, bottom;
    logic signed [25:0] lx, ly;
    always_comb
    begin
        right  = (k_reg == 2'd1) || (k_reg == 2'd2);
        bottom = k_reg[1];
        lx = (right ? 26'(sd_reg.w) : 26'sd0) - 26'(sd_reg.px);
        ly = (bottom ? 26'(sd_reg.h) : 26'sd0) - 26'(sd_reg.py);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            k_reg     <= 2'd0;
            b_vld_reg <= 1'b0;
            valid     <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_vld_reg <= in_valid;
                k_reg     <= 2'd0;
            end
            else if (adv_b)
                k_reg <= k_reg + 2'd1;
            if (adv_b)
                b_vld_reg <= a_vld_reg;
            if (adv_c)
                valid <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            c_reg   <= cin.neg ? -cin.x : cin.x;
            s_reg   <= cin.neg ? -cin.y : cin.y;
            rot_reg <= cin.rot;
            sd_reg  <= sin;
        end
        if (adv_b)
        begin
            p1_reg   <= 68'(c_reg) * 68'(lx);
            p2_reg   <= 68'(s_reg) * 68'(ly);
            p3_reg   <= 68'(s_reg) * 68'(lx);
            p4_reg   <= 68'(c_reg) * 68'(ly);
            lx_reg   <= lx;
            ly_reg   <= ly;
            brot_reg <= rot_reg;
            bk_reg   <= k_reg;
            bsd_reg  <= sd_reg;
        end
    end

    function automatic logic signed [15:0] fin(input logic signed [39:0] v);
        logic [39:0] m;
        logic signed [39:0] t;
        m = v[39] ? 40'(-v) : 40'(v);
        m = m >> FRAC_BITS;
        t = v[39] ? -$signed(m) : $signed(m);
        if (t > 40'sd32767)
            return 16'sd32767;
        if (t < -40'sd32768)
            return -16'sd32768;
        return t[15:0];
    endfunction

    logic signed [67:0] rx_full, ry_full;
    logic signed [39:0] fx, fy;
    logic umax, vmax, br, bb;
    always_comb
    begin
        rx_full = p1_reg - p2_reg + 68'sd536870912;
        ry_full = p3_reg + p4_reg + 68'sd536870912;
        if (brot_reg)
        begin
            fx = 40'(rx_full >>> 30) + 40'(bsd_reg.ox);
            fy = 40'(ry_full >>> 30) + 40'(bsd_reg.oy);
        end
        else
        begin
            fx = 40'(lx_reg) + 40'(bsd_reg.ox);
            fy = 40'(ly_reg) + 40'(bsd_reg.oy);
        end
        br = (bk_reg == 2'd1) || (bk_reg == 2'd2);
        bb = bk_reg[1];
        umax = br ^ bsd_reg.flips[0];
        vmax = bb ^ bsd_reg.flips[1];
    end

    always_ff @(posedge clk)
    begin
        if (adv_c)
        begin
            corner       <= bk_reg;
            pos_x        <= fin(fx);
            pos_y        <= fin(fy);
            pos_z        <= bsd_reg.depth;
            tex_u        <= umax ? bsd_reg.tmax[15:0] : bsd_reg.tmin[15:0];
            tex_v        <= vmax ? bsd_reg.tmax[31:16] : bsd_reg.tmin[31:16];
            vertex_color <= bsd_reg.tint;
            last_vertex  <= (bk_reg == 2'd3);
        end
    end
endmodule
`default_nettype wire

@@ src/sprite_quad_vertex_gen.sv @@
// A sprite passes the CORDIC cells, then emit stages A, B and C; its vertices follow one a cycle
// while out_stall is low. The emit stage takes a new sprite only as its fourth vertex moves on.
// The CORDIC is a chain of one cell per iteration; it holds only while its last cell
// carries a sprite that the emit stage cannot take.
// Reset clears all valid flags; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module sprite_quad_vertex_gen
    import sqvg_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire signed [23:0]  dest_min_x,
    input  wire signed [23:0]  dest_min_y,
    input  wire signed [23:0]  dest_max_x,
    input  wire signed [23:0]  dest_max_y,
    input  wire signed [23:0]  pivot_x,
    input  wire signed [23:0]  pivot_y,
    input  wire signed [15:0]  angle,
    input  wire signed [15:0]  depth,
    input  wire [1:0]          flip_flags,
    input  wire [31:0]         tint,
    input  wire [31:0]         tex_min_uv,
    input  wire [31:0]         tex_max_uv,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [1:0]         corner,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic [15:0]        tex_u,
    output logic [15:0]        tex_v,
    output logic [31:0]        vertex_color,
    output logic               last_vertex
);
    cordic_t c0;
    side_t   s0;
    logic [31:0] a32;
    logic        negq;

    always_comb
    begin
        a32  = {angle, 16'h0000};
        negq = (a32[31:30] == 2'd1) || (a32[31:30] == 2'd2);
        c0.x   = CORDIC_GAIN;
        c0.y   = '0;
        c0.z   = ZW'($signed(negq ? (a32 + 32'h80000000) : a32));
        c0.neg = negq;
        c0.rot = (angle != 16'sd0);
        s0.w     = 25'(dest_max_x) - 25'(dest_min_x);
        s0.h     = 25'(dest_max_y) - 25'(dest_min_y);
        s0.px    = pivot_x;
        s0.py    = pivot_y;
        s0.ox    = 25'(dest_min_x) + 25'(pivot_x);
        s0.oy    = 25'(dest_min_y) + 25'(pivot_y);
        s0.depth = depth;
        s0.flips = flip_flags;
        s0.tint  = tint;
        s0.tmin  = tex_min_uv;
        s0.tmax  = tex_max_uv;
    end

    logic    en;
    logic    tail_stall;
    logic    vld [RUN_STAGES+1];
    cordic_t cc  [RUN_STAGES+1];
    side_t   ss  [RUN_STAGES+1];

    assign vld[0] = in_valid;
    assign cc[0]  = c0;
    assign ss[0]  = s0;
    assign en     = !tail_stall || !vld[RUN_STAGES];
    assign in_stall = !en;

    for (genvar g = 0; g < RUN_STAGES; g++)
    begin : g_cell
        sqvg_cordic_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (CIDX_W'(g)),
            .en      (en),
            .vld_in  (vld[g]),
            .cin     (cc[g]),
            .sin     (ss[g]),
            .vld_out (vld[g+1]),
            .cout    (cc[g+1]),
            .sout    (ss[g+1])
        );
    end

    sqvg_vertex_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (vld[RUN_STAGES]),
        .in_stall     (tail_stall),
        .cin          (cc[RUN_STAGES]),
        .sin          (ss[RUN_STAGES]),
        .valid        (out_valid),
        .stall        (out_stall),
        .corner       (corner),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_color (vertex_color),
        .last_vertex  (last_vertex)
    );

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_vertex == (corner == 2'd3)))
        else $error("last_vertex mismatch");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && corner != 2'd3) |=> (out_valid && corner == $past(corner) + 2'd1))
        else $error("corner order broken");
endmodule
`default_nettype wire
